>>> rtl/thrt_pkg.sv
// Package for the thermistor resistance to temperature converter.
// Holds widths, the NTC lookup table and the control structs shared by
// the top level and the serial divider. No dependencies.
package thrt_pkg;

  // Table size and the number of entries the scan actually walks.
  localparam int TABLE_ENTRIES  = 38;
  localparam int STORED_ENTRIES = 38;
  localparam int USED_ENTRIES   = (TABLE_ENTRIES > STORED_ENTRIES) ?
                                  STORED_ENTRIES : TABLE_ENTRIES;
  localparam int IDX_W          = $clog2(STORED_ENTRIES);

  // Field widths.
  localparam int RES_W  = 16;  // resistance in ohms
  localparam int TEMP_W = 9;   // signed degrees Celsius
  localparam int NOM_W  = 23;  // table resistance in hundredths of an ohm
  localparam int X_W    = NOM_W + 3;  // five times a resistance difference

  // Divider sizing: the quotient of the interpolation step is below five.
  localparam int DIV_STEPS = 3;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Signed temperature reset values.
  localparam logic signed [TEMP_W-1:0] CUR_TEMP_RESET   = '0;
  localparam logic signed [TEMP_W-1:0] SHOWN_TEMP_RESET = -9'sd50;

  // Configuration register indexes.
  localparam logic REG_LOW_LIMIT  = 1'b0;
  localparam logic REG_HIGH_LIMIT = 1'b1;

  localparam logic [RES_W-1:0] LOW_LIMIT_RESET  = 16'd250;
  localparam logic [RES_W-1:0] HIGH_LIMIT_RESET = 16'd55187;

  // One row of the NTC table: degree, nominal value and tolerance band.
  typedef struct packed {
    logic signed [TEMP_W-1:0] deg;
    logic [NOM_W-1:0]         nom;
    logic [NOM_W-1:0]         lo;
    logic [NOM_W-1:0]         hi;
  } ntc_row_t;

  localparam ntc_row_t NTC_TAB [STORED_ENTRIES] = '{
    '{-9'sd40, 23'd5287200, 23'd5055700, 23'd5518700},
    '{-9'sd40, 23'd5287200, 23'd5055700, 23'd5518700},
    '{-9'sd35, 23'd3999900, 23'd3837600, 23'd4162300},
    '{-9'sd30, 23'd3047000, 23'd2932700, 23'd3161300},
    '{-9'sd25, 23'd2334000, 23'd2253400, 23'd2414700},
    '{-9'sd20, 23'd1804100, 23'd1746900, 23'd1861300},
    '{-9'sd15, 23'd1400500, 23'd1359800, 23'd1441100},
    '{-9'sd10, 23'd1096500, 23'd1067500, 23'd1125400},
    '{-9'sd5,  23'd865200,  23'd844600,  23'd885800},
    '{9'sd0,   23'd688000,  23'd673200,  23'd702700},
    '{9'sd5,   23'd549800,  23'd539300,  23'd560300},
    '{9'sd10,  23'd442500,  23'd435100,  23'd449900},
    '{9'sd15,  23'd358100,  23'd352800,  23'd363300},
    '{9'sd20,  23'd291700,  23'd288000,  23'd295400},
    '{9'sd25,  23'd240000,  23'd237600,  23'd242400},
    '{9'sd30,  23'd199100,  23'd196700,  23'd201600},
    '{9'sd35,  23'd164700,  23'd162400,  23'd167100},
    '{9'sd40,  23'd137000,  23'd134800,  23'd139300},
    '{9'sd45,  23'd115200,  23'd113200,  23'd117300},
    '{9'sd50,  23'd97310,   23'd95390,   23'd99230},
    '{9'sd55,  23'd82010,   23'd80250,   23'd83760},
    '{9'sd60,  23'd69480,   23'd67880,   23'd71080},
    '{9'sd65,  23'd59310,   23'd57850,   23'd60770},
    '{9'sd70,  23'd50840,   23'd49510,   23'd52170},
    '{9'sd75,  23'd43670,   23'd42460,   23'd44870},
    '{9'sd80,  23'd37630,   23'd36540,   23'd38730},
    '{9'sd85,  23'd32620,   23'd31620,   23'd33620},
    '{9'sd90,  23'd28370,   23'd27470,   23'd29280},
    '{9'sd95,  23'd24820,   23'd23990,   23'd25640},
    '{9'sd100, 23'd21780,   23'd21030,   23'd22530},
    '{9'sd105, 23'd19110,   23'd18430,   23'd19800},
    '{9'sd110, 23'd16820,   23'd16200,   23'd17450},
    '{9'sd115, 23'd14850,   23'd14290,   23'd15420},
    '{9'sd120, 23'd13150,   23'd12630,   23'd13670},
    '{9'sd125, 23'd11690,   23'd11220,   23'd12160},
    '{9'sd130, 23'd10420,   23'd9986,    23'd10850},
    '{9'sd135, 23'd9293,    23'd8897,    23'd9690},
    '{9'sd140, 23'd8308,    23'd7944,    23'd8671}
  };

  // Divider control and status.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/thermistor_resistance_to_temperature_core.sv
// Thermistor resistance to temperature converter, top level.
// Sequencer, table scan and result word register; uses thrt_div and thrt_pkg.
//
//   channel  direction  handshake               payload
//   input    in         in_valid / in_stall     resistance
//   output   out        out_valid / out_stall   temperature, sensor_fault, changed
//   config   in         cfg_we (no wait)        cfg_index, cfg_data
//
// A word out of limits goes from accept straight to the finish step. A word
// inside a tolerance band leaves the band scan at its table entry; a word found
// by interpolation takes the band checks of all 38 entries, one pair check per
// pair up to the match, an operand step, 3 divider steps and a done step. A
// word with no match runs through all band and pair checks to the finish step;
// a stalled output holds the word in the finish step.
// Reset is synchronous; the block can accept a word at the first rising edge
// after rst is released.
// A held result word on the output does not block the next input word; only
// its finish step waits for the output register to free up.
module thermistor_resistance_to_temperature_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [thrt_pkg::RES_W-1:0]         resistance,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [thrt_pkg::TEMP_W-1:0] temperature,
  output logic                               sensor_fault,
  output logic                               changed,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [thrt_pkg::RES_W-1:0]         cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_BAND   = 6'b000010,
    ST_PAIR   = 6'b000100,
    ST_DIFF   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                             state;
  logic [thrt_pkg::RES_W-1:0]         low_limit;
  logic [thrt_pkg::RES_W-1:0]         high_limit;
  logic [thrt_pkg::IDX_W-1:0]         idx;
  logic [thrt_pkg::NOM_W-1:0]         rs;
  logic [thrt_pkg::NOM_W-1:0]         rs_next;
  logic [thrt_pkg::NOM_W-1:0]         den;
  logic [thrt_pkg::NOM_W-1:0]         diff;
  logic signed [thrt_pkg::TEMP_W-1:0] deg_base;
  logic signed [thrt_pkg::TEMP_W-1:0] cur_temp;
  logic signed [thrt_pkg::TEMP_W-1:0] shown_temp;
  logic                               shown_error;
  logic                               err;
  logic                               in_accept;
  logic                               out_free;
  logic                               range_err;
  thrt_pkg::ntc_row_t                 row;
  thrt_pkg::ntc_row_t                 row_nxt;
  thrt_pkg::div_ctrl_t                div_ctrl;
  thrt_pkg::div_stat_t                div_stat;
  logic [thrt_pkg::X_W-1:0]           div_x;
  logic [thrt_pkg::DIV_STEPS-1:0]     div_q;
  logic [thrt_pkg::X_W-1:0]           div_rem;
  logic signed [thrt_pkg::TEMP_W-1:0] interp_sum;
  logic signed [thrt_pkg::TEMP_W-1:0] interp_temp;
  logic                               word_changed;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Reading times 100 as a shift-and-add, and the limit check.
  assign rs_next = (thrt_pkg::NOM_W'(resistance) << 6) +
                   (thrt_pkg::NOM_W'(resistance) << 5) +
                   (thrt_pkg::NOM_W'(resistance) << 2);
  assign range_err = (resistance < low_limit) || (resistance > high_limit);

  // Table rows at the scan index and its neighbor.
  assign row     = thrt_pkg::NTC_TAB[idx];
  assign row_nxt = thrt_pkg::NTC_TAB[idx + thrt_pkg::IDX_W'(1)];

  // Divider operands: dividend is five times the distance from the upper node.
  assign div_x          = (thrt_pkg::X_W'(diff) << 2) + thrt_pkg::X_W'(diff);
  assign div_ctrl.start = (state == ST_DIFF);

  // Truncation toward zero: a negative sum with a remainder rounds up by one.
  assign interp_sum  = deg_base + $signed({{(thrt_pkg::TEMP_W-thrt_pkg::DIV_STEPS){1'b0}},
                                           div_q});
  assign interp_temp = (interp_sum < 0 && div_rem != '0) ?
                       interp_sum + thrt_pkg::TEMP_W'(1) : interp_sum;

  assign word_changed = (shown_temp != cur_temp) || (shown_error != err);

  thrt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_x),
    .divisor   (den),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= thrt_pkg::LOW_LIMIT_RESET;
      high_limit <= thrt_pkg::HIGH_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thrt_pkg::REG_LOW_LIMIT:  low_limit  <= cfg_data;
        thrt_pkg::REG_HIGH_LIMIT: high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: band scan, pair scan and divide as needed, then output the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      err         <= 1'b0;
      cur_temp    <= thrt_pkg::CUR_TEMP_RESET;
      shown_temp  <= thrt_pkg::SHOWN_TEMP_RESET;
      shown_error <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Output valid is set by the finish step and cleared once taken.
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (in_accept) begin
            err   <= range_err;
            state <= range_err ? ST_FINISH : ST_BAND;
          end
        end
        ST_BAND: begin
          if (row.lo < rs && row.hi > rs) begin
            cur_temp <= row.deg;
            state    <= ST_FINISH;
          end else if (idx == thrt_pkg::IDX_W'(thrt_pkg::USED_ENTRIES - 1)) begin
            idx   <= '0;
            state <= ST_PAIR;
          end else begin
            idx <= idx + thrt_pkg::IDX_W'(1);
          end
        end
        ST_PAIR: begin
          if (row.nom > rs && row_nxt.nom < rs) begin
            state <= ST_DIFF;
          end else if (idx == thrt_pkg::IDX_W'(thrt_pkg::USED_ENTRIES - 2)) begin
            state <= ST_FINISH;
          end else begin
            idx <= idx + thrt_pkg::IDX_W'(1);
          end
        end
        ST_DIFF: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            cur_temp <= interp_temp;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            shown_temp  <= cur_temp;
            shown_error <= err;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers for the scan and the interpolation operands.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rs <= rs_next;
    end
    if (state == ST_PAIR) begin
      den      <= row.nom - row_nxt.nom;
      diff     <= row.nom - rs;
      deg_base <= row.deg;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      temperature  <= cur_temp;
      sensor_fault <= err;
      changed      <= word_changed;
    end
  end

  // An accepted word always starts a scan or goes straight to finish.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_BAND || state == ST_FINISH))
    else $error("accepted word did not start processing");

  // The divider only reports completion while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider done outside the divide step");

  // While waiting on the divider, the divider is working or just finished.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divide step without an active divider");

  // A new result word is only loaded from the finish step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result word loaded outside the finish step");

endmodule

>>> rtl/thrt_div.sv
// Serial restoring divider for the interpolation step of the converter.
// Produces one quotient bit per cycle, most significant first.
// Depends on thrt_pkg.
module thrt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  thrt_pkg::div_ctrl_t                ctrl,
  input  logic [thrt_pkg::X_W-1:0]           dividend,
  input  logic [thrt_pkg::NOM_W-1:0]         divisor,
  output thrt_pkg::div_stat_t                stat,
  output logic [thrt_pkg::DIV_STEPS-1:0]     quotient,
  output logic [thrt_pkg::X_W-1:0]           remainder
);

  logic [thrt_pkg::STEP_W-1:0]   step;
  logic [thrt_pkg::NOM_W-1:0]    den;
  logic [thrt_pkg::X_W-1:0]      trial;
  logic                          fits;

  // Shifted divisor for the current quotient bit.
  assign trial = thrt_pkg::X_W'(den) << step;
  assign fits  = remainder >= trial;

  // Control: busy from start until the last quotient bit is known.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      step <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit.
      stat.done <= stat.busy && !ctrl.start && (step == '0);
      if (ctrl.start) begin
        stat.busy <= 1'b1;
        step      <= thrt_pkg::STEP_W'(thrt_pkg::DIV_STEPS - 1);
      end else if (stat.busy) begin
        if (step == '0) begin
          stat.busy <= 1'b0;
        end else begin
          step <= step - thrt_pkg::STEP_W'(1);
        end
      end
    end
  end

  // Datapath: one compare and subtract per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      remainder <= dividend;
      den       <= divisor;
      quotient  <= '0;
    end else if (stat.busy) begin
      if (fits) begin
        remainder <= remainder - trial;
      end
      quotient <= {quotient[thrt_pkg::DIV_STEPS-2:0], fits};
    end
  end

endmodule
